// ===== hdl/u8u16_pkg.sv =====
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// Depends on nothing; every other file in hdl/ imports it.
`default_nettype none

package u8u16_pkg;

  // Lead byte classes, valued as the total byte count of the sequence
  typedef enum logic [2:0] {
    LEAD_CONT  = 3'd0,
    LEAD_ASCII = 3'd1,
    LEAD_TWO   = 3'd2,
    LEAD_THREE = 3'd3,
    LEAD_FOUR  = 3'd4,
    LEAD_FIVE  = 3'd5
  } lead_e;

  // Output sequencer phase: first unit of an event, or pending low surrogate
  typedef enum logic {
    PH_FIRST = 1'b0,
    PH_LOW   = 1'b1
  } phase_e;

  localparam int unsigned PointW = 21;
  localparam int unsigned UnitW  = 16;

  localparam logic [UnitW-1:0]  ReplReset = 16'h003F;
  localparam logic [UnitW-1:0]  HighBase  = 16'hD800;
  localparam logic [UnitW-1:0]  LowBase   = 16'hDC00;
  localparam logic [PointW-1:0] PlaneOne  = 21'h10000;

  // One decoded event handed from the front to the back
  typedef struct packed {
    logic              bad;
    logic              str_last;
    logic [PointW-1:0] point;
  } cp_evt_t;

  function automatic lead_e lead_class(input logic [4:0] top);
    lead_e cls;
    priority if (top[4] == 1'b0)          cls = LEAD_ASCII;
    else if (top[4:3] == 2'b10)           cls = LEAD_CONT;
    else if (top[4:2] == 3'b110)          cls = LEAD_TWO;
    else if (top[4:1] == 4'b1110)         cls = LEAD_THREE;
    else if (top == 5'b11110)             cls = LEAD_FOUR;
    else                                  cls = LEAD_FIVE;
    return cls;
  endfunction

  function automatic logic [7:0] lead_mask(input lead_e cls);
    logic [7:0] m;
    unique case (cls)
      LEAD_ASCII: m = 8'h7F;
      LEAD_TWO:   m = 8'h1F;
      LEAD_THREE: m = 8'h0F;
      LEAD_FOUR:  m = 8'h07;
      default:    m = 8'h00;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/u8u16_front.sv =====
// Front end: accepts bytes, tracks the open sequence, pushes decoded events.
// Depends on u8u16_pkg.
`default_nettype none

module u8u16_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [7:0]        byte_in_i,
  input  wire logic              string_last_i,
  input  wire logic              space_i,
  output logic                   push_o,
  output u8u16_pkg::cp_evt_t     evt_o
);
  import u8u16_pkg::*;

  logic [2:0]        left_q, left_d;
  logic [PointW-1:0] part_q, part_d;
  logic              bad_q, bad_d;

  logic              accept;
  lead_e             cls;
  logic              bad_n;
  logic [PointW-1:0] part_n;
  logic [2:0]        left_n;

  assign in_ready_o = space_i;
  assign accept     = in_valid_i && space_i;
  assign cls        = lead_class(byte_in_i[7:3]);
  assign bad_n      = bad_q | (byte_in_i[7:6] != 2'b10);
  assign part_n     = {part_q[PointW-7:0], byte_in_i[5:0]};
  assign left_n     = left_q - 3'd1;

  always_comb begin
    left_d          = left_q;
    part_d          = part_q;
    bad_d           = bad_q;
    push_o          = 1'b0;
    evt_o.bad       = 1'b0;
    evt_o.str_last  = string_last_i;
    evt_o.point     = '0;
    if (accept) begin
      if (left_q == 3'd0) begin
        unique case (cls)
          LEAD_CONT: begin
            push_o    = 1'b1;
            evt_o.bad = 1'b1;
          end
          LEAD_ASCII: begin
            push_o      = 1'b1;
            evt_o.point = {{(PointW-8){1'b0}}, byte_in_i};
          end
          default: begin
            // open a multi-byte sequence; a five-byte lead is bad from the start
            left_d = 3'(cls) - 3'd1;
            part_d = {{(PointW-8){1'b0}}, byte_in_i & lead_mask(cls)};
            bad_d  = (cls == LEAD_FIVE);
            if (string_last_i) begin
              push_o    = 1'b1;
              evt_o.bad = 1'b1;
              left_d    = 3'd0;
              part_d    = '0;
              bad_d     = 1'b0;
            end
          end
        endcase
      end else begin
        left_d = left_n;
        part_d = part_n;
        bad_d  = bad_n;
        if (left_n == 3'd0) begin
          push_o      = 1'b1;
          evt_o.bad   = bad_n;
          evt_o.point = part_n;
          part_d      = '0;
          bad_d       = 1'b0;
        end else if (string_last_i) begin
          // cut off by end of string
          push_o    = 1'b1;
          evt_o.bad = 1'b1;
          left_d    = 3'd0;
          part_d    = '0;
          bad_d     = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= 3'd0;
      part_q <= '0;
      bad_q  <= 1'b0;
    end else begin
      left_q <= left_d;
      part_q <= part_d;
      bad_q  <= bad_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/u8u16_fifo.sv =====
// Short event queue between front and back ends.
// Depends on u8u16_pkg for the event type.
`default_nettype none

module u8u16_fifo #(
  parameter int unsigned Depth = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire u8u16_pkg::cp_evt_t push_data_i,
  output logic                   space_o,
  output logic                   valid_o,
  output u8u16_pkg::cp_evt_t     data_o,
  input  wire logic              pop_i
);
  import u8u16_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  cp_evt_t         entry_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign space_o = (cnt_q != CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = entry_q[rd_q];
  assign do_push = push_i && space_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_q] <= push_data_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue fill count beyond depth");

  a_no_lost_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> space_o)
    else $error("event pushed into a full queue");

endmodule

`default_nettype wire

// ===== hdl/u8u16_back.sv =====
// Back end: turns queued events into UTF-16 units, splits surrogate pairs,
// holds the replacement register and the output register. Depends on u8u16_pkg.
`default_nettype none

module u8u16_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [15:0]         replacement_unit_i,
  input  wire logic                evt_valid_i,
  input  wire u8u16_pkg::cp_evt_t  evt_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [15:0]              code_unit_o,
  output logic                     run_end_o,
  output logic                     string_end_o,
  output logic                     invalid_o
);
  import u8u16_pkg::*;

  phase_e            phase_q, phase_d;
  logic [UnitW-1:0]  repl_q;
  logic              vld_q, vld_d;
  logic [UnitW-1:0]  unit_q, unit_d;
  logic              run_end_q, run_end_d;
  logic              str_end_q, str_end_d;
  logic              inv_q, inv_d;
  logic [UnitW-1:0]  low_q, low_d;
  logic              low_last_q, low_last_d;

  logic              load;
  logic              is_pair;
  logic [PointW-1:0] offs;

  assign load    = !vld_q || out_ready_i;
  assign pop_o   = load && (phase_q == PH_FIRST) && evt_valid_i;
  assign is_pair = !evt_i.bad && (evt_i.point[PointW-1:UnitW] != '0);
  assign offs    = evt_i.point - PlaneOne;

  // next phase
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PH_FIRST: if (pop_o && is_pair) phase_d = PH_LOW;
      PH_LOW:   if (load) phase_d = PH_FIRST;
      default:  phase_d = PH_FIRST;
    endcase
  end

  // next output register contents
  always_comb begin
    vld_d      = vld_q && !out_ready_i;
    unit_d     = unit_q;
    run_end_d  = run_end_q;
    str_end_d  = str_end_q;
    inv_d      = inv_q;
    low_d      = low_q;
    low_last_d = low_last_q;
    if (load && (phase_q == PH_LOW)) begin
      vld_d     = 1'b1;
      unit_d    = low_q;
      run_end_d = 1'b1;
      str_end_d = low_last_q;
      inv_d     = 1'b0;
    end else if (pop_o) begin
      vld_d = 1'b1;
      if (evt_i.bad) begin
        unit_d    = repl_q;
        run_end_d = 1'b1;
        str_end_d = evt_i.str_last;
        inv_d     = 1'b1;
      end else if (is_pair) begin
        unit_d     = HighBase + UnitW'(offs[PointW-1:10]);
        run_end_d  = 1'b0;
        str_end_d  = 1'b0;
        inv_d      = 1'b0;
        low_d      = LowBase + UnitW'(offs[9:0]);
        low_last_d = evt_i.str_last;
      end else begin
        unit_d    = evt_i.point[UnitW-1:0];
        run_end_d = 1'b1;
        str_end_d = evt_i.str_last;
        inv_d     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FIRST;
      vld_q   <= 1'b0;
      repl_q  <= ReplReset;
    end else begin
      phase_q <= phase_d;
      vld_q   <= vld_d;
      if (cfg_we_i) begin
        repl_q <= replacement_unit_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unit_q     <= unit_d;
    run_end_q  <= run_end_d;
    str_end_q  <= str_end_d;
    inv_q      <= inv_d;
    low_q      <= low_d;
    low_last_q <= low_last_d;
  end

  assign out_valid_o  = vld_q;
  assign code_unit_o  = unit_q;
  assign run_end_o    = run_end_q;
  assign string_end_o = str_end_q;
  assign invalid_o    = inv_q;

  a_low_pending_shows_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_LOW) |-> (vld_q && !run_end_q && !inv_q))
    else $error("low surrogate pending without a high surrogate on the output");

  a_pair_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && is_pair) |=> (phase_q == PH_LOW))
    else $error("surrogate pair split lost its low half");

endmodule

`default_nettype wire

// ===== hdl/utf8_to_utf16_transcoder.sv =====
// Top level of the UTF-8 to UTF-16 transcoder: front end, event queue, back end.
// Depends on u8u16_pkg, u8u16_front, u8u16_fifo and u8u16_back.
`default_nettype none

// Channel   Direction  Handshake               Payload
// in        input      in_valid_i/in_ready_o   byte_in_i[7:0], string_last_i
// out       output     out_valid_o/out_ready_i code_unit_o[15:0], run_end_o,
//                                              string_end_o, invalid_o
// cfg       input      cfg_we_i (no wait)      replacement_unit_i[15:0]
//
// One byte is taken per cycle while the event queue has room; each byte yields
// at most one event (a code point or a replacement).
// The back end emits one unit per cycle while out_ready_i is high; a code
// point above 0xFFFF yields two units (high then low surrogate), which the
// queue absorbs. An event passes through the queue, then the output register.
// Reset clears the open sequence, the queue and the output register, and sets
// the replacement unit to '?'. Input and output stall independently.

module utf8_to_utf16_transcoder #(
  parameter int unsigned FifoDepth = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  byte_in_i,
  input  wire logic        string_last_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [15:0]      code_unit_o,
  output logic             run_end_o,
  output logic             string_end_o,
  output logic             invalid_o,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] replacement_unit_i
);
  import u8u16_pkg::*;

  // front -> queue
  logic    push;
  cp_evt_t push_evt;
  logic    space;
  // queue -> back
  logic    evt_valid;
  cp_evt_t evt;
  logic    pop;

  u8u16_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .byte_in_i     (byte_in_i),
    .string_last_i (string_last_i),
    .space_i       (space),
    .push_o        (push),
    .evt_o         (push_evt)
  );

  u8u16_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_evt),
    .space_o     (space),
    .valid_o     (evt_valid),
    .data_o      (evt),
    .pop_i       (pop)
  );

  // drain events into units; surrogate pairs hold the queue while the low half is pending
  u8u16_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .replacement_unit_i (replacement_unit_i),
    .evt_valid_i        (evt_valid),
    .evt_i              (evt),
    .pop_o              (pop),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .code_unit_o        (code_unit_o),
    .run_end_o          (run_end_o),
    .string_end_o       (string_end_o),
    .invalid_o          (invalid_o)
  );

endmodule

`default_nettype wire
